/* design/slt_pkg.sv */
// shared types and constants for the sorted list table
`default_nettype none
package slt_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMPW  = (CW > 4) ? CW : 4;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_READ     = 2'd1,
    KIND_RM_VALUE = 2'd2,
    KIND_RM_POS   = 2'd3
  } slt_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } slt_status_t;

  typedef struct packed {
    slt_kind_t          kind;
    logic signed [31:0] value;
    logic [3:0]         position;
  } slt_in_t;

  typedef struct packed {
    slt_status_t        status;
    logic signed [31:0] data;
    logic [4:0]         count;
  } slt_out_t;

endpackage
`default_nettype wire

/* design/sorted_list_table.sv */
// sorted list table: ascending list of signed values kept in one ram
// a rejected request (full, empty, bad position) gives its result in the cycle after start
// read: ram read, then result; insert: shifts larger entries up from the end, one ram write each
// removals: find the value or go to the position, then move each later entry down one place
// busy is high while a request walks the ram; a new item is taken only while idle, the next one
// can be taken in the cycle its result shows; results cannot be stalled
// synchronous active-low reset empties the list; ram contents are not cleared
`default_nettype none
module sorted_list_table
  import slt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire slt_in_t in_item,
  output logic         out_valid,
  output slt_out_t     out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_READ,
    S_FIND,
    S_SHIFT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic signed [31:0]  val_r;
  logic                out_valid_r;
  slt_out_t            out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [31:0]         ram_wdata, ram_rdata;

  logic                fin;
  slt_status_t         fin_status;
  logic signed [31:0]  fin_data;
  logic [CMPW-1:0]     posx, usedx;

  slt_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy  = (state_r != S_IDLE);
  assign posx  = CMPW'(in_item.position);
  assign usedx = CMPW'(used_r);

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    idx_nxt    = idx_r;
    ram_we     = 1'b0;
    ram_waddr  = AW'(idx_r);
    ram_wdata  = ram_rdata;
    ram_raddr  = '0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_data   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_item.kind)
            KIND_INSERT: begin
              if (used_r == CW'(DEPTH)) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else if (used_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_item.value;
                used_nxt  = used_r + CW'(1);
                fin       = 1'b1;
              end else begin
                ram_raddr = AW'(used_r - CW'(1));
                idx_nxt   = used_r;
                state_nxt = S_INS;
              end
            end
            KIND_READ: begin
              if (posx >= usedx) begin
                fin        = 1'b1;
                fin_status = ST_BADPOS;
              end else begin
                ram_raddr = AW'(posx);
                state_nxt = S_READ;
              end
            end
            KIND_RM_VALUE: begin
              if (used_r == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            KIND_RM_POS: begin
              if (posx >= usedx) begin
                fin        = 1'b1;
                fin_status = ST_BADPOS;
              end else if (usedx - posx == CMPW'(1)) begin
                // last entry: nothing to move down
                used_nxt = used_r - CW'(1);
                fin      = 1'b1;
              end else begin
                ram_raddr = AW'(posx + CMPW'(1));
                idx_nxt   = CW'(posx);
                state_nxt = S_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        // rdata holds entries[idx-1]
        if ($signed(val_r) < $signed(ram_rdata)) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_r);
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - CW'(1);
          ram_raddr = AW'(idx_r - CW'(2));
          if (idx_r == CW'(1)) begin
            state_nxt = S_INS_PUT;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_r);
          ram_wdata = val_r;
          used_nxt  = used_r + CW'(1);
          fin       = 1'b1;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        used_nxt  = used_r + CW'(1);
        fin       = 1'b1;
      end
      S_READ: begin
        fin      = 1'b1;
        fin_data = ram_rdata;
      end
      S_FIND: begin
        // next entry is fetched either way: it feeds the shift on a match
        ram_raddr = AW'(idx_r + CW'(1));
        if (ram_rdata == val_r) begin
          if (idx_r + CW'(1) < used_r) begin
            state_nxt = S_SHIFT;
          end else begin
            used_nxt = used_r - CW'(1);
            fin      = 1'b1;
          end
        end else if (idx_r + CW'(1) == used_r) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SHIFT: begin
        // rdata holds entries[idx+1], move it down one place
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        ram_wdata = ram_rdata;
        ram_raddr = AW'(idx_r + CW'(2));
        if (idx_r + CW'(2) < used_r) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          used_nxt = used_r - CW'(1);
          fin      = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end

    out_nxt.status = fin_status;
    out_nxt.data   = fin_data;
    out_nxt.count  = 5'(used_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= fin;
    end
    idx_r <= idx_nxt;
    if (state_r == S_IDLE && start) begin
      val_r <= in_item.value;
    end
    if (fin) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

/* design/slt_ram.sv */
// generic single write, single read ram with registered read data
`default_nettype none
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* design/sorted_list_table_chk.sv */
// port-level checks for the sorted list table, bound to the top level
`default_nettype none
module sorted_list_table_chk
  import slt_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire slt_in_t  in_item,
  input wire logic     out_valid,
  input wire slt_out_t out_item
);

  // an accepted item either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted item neither answered nor busy");

  // the result strobe comes only once the block is free again
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // finishing a long request always gives a result
  a_fall_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without result");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |-> out_item.count == 5'(DEPTH))
    else $error("full reported below capacity");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.data == '0)
    else $error("failed request returned data");

endmodule

bind sorted_list_table sorted_list_table_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
